[rtl/core/gqlw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gqlw_pkg
// Shared widths, register indexes, item types and the pen clamp for the glyph
// quad layout core.
// ----------------------------------------------------------------------------
package gqlw_pkg;

  // Field and state widths.
  localparam int PEN_W   = 17;
  localparam int OUT_W   = 25;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NWW_W   = 16;
  localparam int PROD_W  = 29;  // holds (width + bearing) * scale, signed
  localparam int ADV_W   = 24;  // advance * scale before the shift
  localparam int LSTEP_W = 26;  // line height * scale before the shift
  localparam int SUM_W   = 28;  // pen plus a step, before the clamp

  // Saturation limits.
  localparam int PEN_MAX = 65535;
  localparam int PEN_MIN = -65536;
  localparam int OUT_MAX = 16777215;
  localparam int OUT_MIN = -16777216;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PEN_START_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEN_START_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT  = 3'd4;

  // One glyph as it sits in the input register.
  typedef struct packed {
    logic        first_glyph;
    logic        is_space;
    logic [7:0]  glyph_x_bearing;
    logic [7:0]  glyph_y_bearing;
    logic [9:0]  glyph_width;
    logic [9:0]  glyph_height;
    logic [7:0]  glyph_advance;
    logic [NWW_W-1:0] next_word_width;
  } in_item_t;

  // Per-glyph request to the pen unit.
  typedef struct packed {
    logic             first_glyph;
    logic             is_space;
    logic [ADV_W-1:0] adv_step;
    logic [NWW_W-1:0] next_word_width;
  } pen_cmd_t;

  // Static pen settings from the configuration registers.
  typedef struct packed {
    logic [CFG_W-1:0]   start_x;
    logic [CFG_W-1:0]   start_y;
    logic [CFG_W-1:0]   wrap_limit;
    logic [LSTEP_W-1:0] line_step;
  } pen_cfg_t;

  // Clamp a widened pen sum into the signed pen range.
  function automatic logic [PEN_W-1:0] sat_pen(input logic signed [SUM_W-1:0] v);
    logic [PEN_W-1:0] r;
    if (v > signed'(SUM_W'(PEN_MAX))) begin
      r = PEN_W'(PEN_MAX);
    end else if (v < signed'(SUM_W'(PEN_MIN))) begin
      r = PEN_W'(PEN_MIN);
    end else begin
      r = v[PEN_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/gqlw_pen_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gqlw_pen_unit
// Holds the pen position, gives the pen for the glyph in hand and applies the
// advance and the word-wrap line feed when the glyph moves on.
// ----------------------------------------------------------------------------
module gqlw_pen_unit
  import gqlw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire pen_cmd_t         cmd,
  input  wire pen_cfg_t         cfg,
  output logic [PEN_W-1:0]      pen_x_cur,
  output logic [PEN_W-1:0]      pen_y_cur
);

  logic [PEN_W-1:0] pen_x;
  logic [PEN_W-1:0] pen_y;
  logic [PEN_W-1:0] pen_x_next;
  logic [PEN_W-1:0] pen_y_next;
  logic [PEN_W-1:0] start_x;
  logic [PEN_W-1:0] start_y;
  logic signed [SUM_W-1:0] x_sum;
  logic signed [SUM_W-1:0] y_sum;
  logic [PEN_W-1:0] x_adv;
  logic [PEN_W-1:0] y_feed;
  logic signed [18:0] x_adv_w;
  logic signed [18:0] x_reach;
  logic signed [18:0] limit_w;
  logic wrap;

  // A first glyph starts from the start position.
  assign start_x   = PEN_W'($signed(cfg.start_x));
  assign start_y   = PEN_W'($signed(cfg.start_y));
  assign pen_x_cur = cmd.first_glyph ? start_x : pen_x;
  assign pen_y_cur = cmd.first_glyph ? start_y : pen_y;

  // Advance, then clamp into the pen range.
  assign x_sum = SUM_W'($signed(pen_x_cur)) + signed'(SUM_W'(cmd.adv_step));
  assign x_adv = sat_pen(x_sum);

  // Line feed candidate.
  assign y_sum  = SUM_W'($signed(pen_y_cur)) + signed'(SUM_W'(cfg.line_step));
  assign y_feed = sat_pen(y_sum);

  // Wrap at a space when the pen or the end of the next word passes the limit.
  assign x_adv_w = 19'($signed(x_adv));
  assign x_reach = x_adv_w + signed'(19'(cmd.next_word_width));
  assign limit_w = 19'($signed(cfg.wrap_limit));
  assign wrap    = cmd.is_space && ((x_adv_w > limit_w) || (x_reach > limit_w));

  assign pen_x_next = wrap ? start_x : x_adv;
  assign pen_y_next = wrap ? y_feed : pen_y_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
    end else if (step) begin
      pen_x <= pen_x_next;
      pen_y <= pen_y_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/glyph_quad_layout_word_wrap_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_quad_layout_word_wrap_core
// Lays out a stream of glyphs: emits each glyph quad's edges in fixed point
// and moves the pen, wrapping lines at spaces.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_axis   in         glyph metrics (tdata), first_glyph / is_space (tuser)
//  m_axis   out        quad left, top, right, bottom (tdata)
//  cfg      in         register write: cfg_wr_en, cfg_index, cfg_data
//
// One glyph per cycle while m_axis is not stalled; a result passes through the input
// register, then the scaled-product register with the pen and edge sums behind it,
// then the output register.
// The rate is set by the pen loop: one add, clamp and wrap compare per cycle.
// Reset loads the register defaults, empties the pipeline and puts the pen at
// the origin. A stall on m_axis fills the stages behind it one by one before
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module glyph_quad_layout_word_wrap_core
  import gqlw_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Glyph requests.
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // x_bearing[7:0], y_bearing[15:8], width[25:16], height[35:26],
  // advance[43:36], next_word_width[59:44], zero pad[63:60]
  input  wire logic [63:0]          s_axis_tdata,
  // first_glyph[0], is_space[1]
  input  wire logic [1:0]           s_axis_tuser,
  // Quad results.
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // quad_left[24:0], quad_top[49:25], quad_right[74:50], quad_bottom[99:75],
  // zero pad[103:100]
  output logic [103:0]              m_axis_tdata,
  // Configuration writes.
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int BASE_W = PEN_W + FRAC_BITS;
  localparam int SW     = ((BASE_W > PROD_W) ? BASE_W : PROD_W) + 1;
  localparam logic signed [SW-1:0] OMAX = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] OMIN = SW'(OUT_MIN);

  typedef struct packed {
    logic [PROD_W-1:0] prod_l;
    logic [PROD_W-1:0] prod_t;
    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_b;
    pen_cmd_t          cmd;
  } scaled_t;

  // Clamp a quad edge into the 25-bit output range.
  function automatic logic [OUT_W-1:0] sat_out(input logic signed [SW-1:0] v);
    logic [OUT_W-1:0] r;
    if (v > OMAX) begin
      r = OMAX[OUT_W-1:0];
    end else if (v < OMIN) begin
      r = OMIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0]   pen_start_x;
  logic [CFG_W-1:0]   pen_start_y;
  logic [CFG_W-1:0]   wrap_limit_x;
  logic [CFG_W-1:0]   text_scale;
  logic [9:0]         line_height;
  logic [LSTEP_W-1:0] line_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_start_x  <= 16'sd0;
      pen_start_y  <= 16'sd0;
      wrap_limit_x <= 16'd32767;
      text_scale   <= 16'd256;
      line_height  <= 10'd16;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PEN_START_X:  pen_start_x  <= cfg_data;
        CFG_PEN_START_Y:  pen_start_y  <= cfg_data;
        CFG_WRAP_LIMIT_X: wrap_limit_x <= cfg_data;
        CFG_TEXT_SCALE:   text_scale   <= cfg_data;
        CFG_LINE_HEIGHT:  line_height  <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // Scaled line height follows the registers; the user must change them only while idle (not enforced here).
  always_ff @(posedge clk) begin
    line_step <= (LSTEP_W'(line_height) * LSTEP_W'(text_scale)) >> FRAC_BITS;
  end

  // Pipeline occupancy and flow control.
  logic     s1_valid;
  logic     s2_valid;
  logic     o_valid;
  logic     o_free;
  logic     s2_free;
  logic     s1_free;
  logic     s2_move;
  in_item_t s1;
  scaled_t  s2;
  scaled_t  s2_next;
  logic [103:0] o_data;

  assign o_free        = !o_valid || m_axis_tready;
  assign s2_free       = !s2_valid || o_free;
  assign s1_free       = !s1_valid || s2_free;
  assign s2_move       = s2_valid && o_free;
  assign s_axis_tready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= s_axis_tvalid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (o_free) begin
        o_valid <= s2_valid;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (s1_free && s_axis_tvalid) begin
      s1.first_glyph     <= s_axis_tuser[0];
      s1.is_space        <= s_axis_tuser[1];
      s1.glyph_x_bearing <= s_axis_tdata[7:0];
      s1.glyph_y_bearing <= s_axis_tdata[15:8];
      s1.glyph_width     <= s_axis_tdata[25:16];
      s1.glyph_height    <= s_axis_tdata[35:26];
      s1.glyph_advance   <= s_axis_tdata[43:36];
      s1.next_word_width <= s_axis_tdata[59:44];
    end
  end

  // Stage 1: bearings, extents and advance times the text scale.
  logic signed [PROD_W-1:0] scale_s;
  logic signed [PROD_W-1:0] xoff_s;
  logic signed [PROD_W-1:0] yoff_s;
  logic signed [PROD_W-1:0] xext_s;
  logic signed [PROD_W-1:0] yext_s;
  logic [ADV_W-1:0]         adv_prod;

  assign scale_s  = signed'(PROD_W'(text_scale));
  assign xoff_s   = PROD_W'($signed(s1.glyph_x_bearing));
  assign yoff_s   = PROD_W'($signed(s1.glyph_y_bearing));
  assign xext_s   = xoff_s + signed'(PROD_W'(s1.glyph_width));
  assign yext_s   = yoff_s + signed'(PROD_W'(s1.glyph_height));
  assign adv_prod = ADV_W'(s1.glyph_advance) * ADV_W'(text_scale);

  always_comb begin
    s2_next.prod_l              = xoff_s * scale_s;
    s2_next.prod_t              = yoff_s * scale_s;
    s2_next.prod_r              = xext_s * scale_s;
    s2_next.prod_b              = yext_s * scale_s;
    s2_next.cmd.first_glyph     = s1.first_glyph;
    s2_next.cmd.is_space        = s1.is_space;
    s2_next.cmd.adv_step        = adv_prod >> FRAC_BITS;
    s2_next.cmd.next_word_width = s1.next_word_width;
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2 <= s2_next;
    end
  end

  // Stage 2: pen position, quad edges and pen update.
  pen_cfg_t         pen_cfg;
  logic [PEN_W-1:0] pen_x_cur;
  logic [PEN_W-1:0] pen_y_cur;

  assign pen_cfg.start_x    = pen_start_x;
  assign pen_cfg.start_y    = pen_start_y;
  assign pen_cfg.wrap_limit = wrap_limit_x;
  assign pen_cfg.line_step  = line_step;

  gqlw_pen_unit u_pen (
    .clk       (clk),
    .rst       (rst),
    .step      (s2_move),
    .cmd       (s2.cmd),
    .cfg       (pen_cfg),
    .pen_x_cur (pen_x_cur),
    .pen_y_cur (pen_y_cur)
  );

  logic signed [SW-1:0] base_x;
  logic signed [SW-1:0] base_y;
  logic [103:0]         o_data_next;

  assign base_x = SW'($signed(pen_x_cur)) <<< FRAC_BITS;
  assign base_y = SW'($signed(pen_y_cur)) <<< FRAC_BITS;

  always_comb begin
    o_data_next          = '0;
    o_data_next[24:0]    = sat_out(base_x + SW'($signed(s2.prod_l)));
    o_data_next[49:25]   = sat_out(base_y + SW'($signed(s2.prod_t)));
    o_data_next[74:50]   = sat_out(base_x + SW'($signed(s2.prod_r)));
    o_data_next[99:75]   = sat_out(base_y + SW'($signed(s2.prod_b)));
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (s2_move) begin
      o_data <= o_data_next;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_data;

  // An empty output register never blocks new requests.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !o_valid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  // A result leaves only when it is taken.
  a_result_taken: assert property (@(posedge clk) disable iff (rst)
    $fell(o_valid) |-> $past(m_axis_tready))
    else $error("result dropped without a transfer");

  // A blocked stage-2 glyph keeps its values.
  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !o_free) |=> (s2_valid && $stable(s2)))
    else $error("stage 2 changed while blocked");

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the glyph quad layout core. A directed table of
// glyphs and register writes runs first, then random text: words, spaces and
// noise glyphs under several register settings and handshake idling patterns.
// Every quad is checked field by field against table values or a pen-tracking layout model.
// ----------------------------------------------------------------------------
module tb;
  import gqlw_pkg::*;

  localparam int FRAC = 8;
  localparam int PHASE_ITEMS = 138;
  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_MID = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 3'd7;

  typedef enum bit {ROW_GLYPH, ROW_CFG} row_kind_e;

  typedef struct {
    bit                 first;
    bit                 space;
    logic signed [7:0]  x_off;
    logic signed [7:0]  y_off;
    logic [9:0]         width;
    logic [9:0]         height;
    logic [7:0]         advance;
    logic [NWW_W-1:0]   nww;
  } glyph_t;

  typedef struct {
    logic [OUT_W-1:0] left;
    logic [OUT_W-1:0] top;
    logic [OUT_W-1:0] right;
    logic [OUT_W-1:0] bottom;
  } quad_t;

  typedef struct {
    row_kind_e          kind;
    glyph_t             g;
    bit                 typed;
    quad_t              quad;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]   val;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Layout model state and its copy of the registers.
  logic signed [PEN_W-1:0] pen_x_m;
  logic signed [PEN_W-1:0] pen_y_m;
  logic signed [CFG_W-1:0] start_x_r;
  logic signed [CFG_W-1:0] start_y_r;
  logic signed [CFG_W-1:0] limit_r;
  logic [CFG_W-1:0] scale_r;
  logic [9:0] lh_r;

  quad_t quad_q[$];
  row_t plan[$];
  int errors = 0;
  int glyphs_sent = 0;
  int quads_checked = 0;
  int wraps = 0;
  int reg_writes = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int word_left = 0;

  glyph_quad_layout_word_wrap_core dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [OUT_W-1:0] sat_edge(longint v);
    if (v > OUT_MAX) begin
      return OUT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      return OUT_W'(OUT_MIN);
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic logic signed [PEN_W-1:0] clamp_pen(longint v);
    if (v > PEN_MAX) begin
      return PEN_W'(PEN_MAX);
    end else if (v < PEN_MIN) begin
      return PEN_W'(PEN_MIN);
    end
    return v[PEN_W-1:0];
  endfunction

  // Register writes as the layout model sees them; spare indexes are ignored.
  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      CFG_PEN_START_X: start_x_r = val;
      CFG_PEN_START_Y: start_y_r = val;
      CFG_WRAP_LIMIT_X: limit_r = val;
      CFG_TEXT_SCALE: scale_r = val;
      CFG_LINE_HEIGHT: lh_r = val[9:0];
      default: ;
    endcase
  endtask

  // Place one glyph at the pen, then advance the pen and wrap at a space.
  task automatic layout_glyph(input glyph_t g, output quad_t q);
    longint sc;
    longint bx;
    longint by;
    longint lim;
    if (g.first) begin
      pen_x_m = PEN_W'(start_x_r);
      pen_y_m = PEN_W'(start_y_r);
    end
    sc = longint'(scale_r);
    bx = longint'(pen_x_m) <<< FRAC;
    by = longint'(pen_y_m) <<< FRAC;
    q.left = sat_edge(bx + longint'(g.x_off) * sc);
    q.top = sat_edge(by + longint'(g.y_off) * sc);
    q.right = sat_edge(bx + (longint'(g.width) + longint'(g.x_off)) * sc);
    q.bottom = sat_edge(by + (longint'(g.height) + longint'(g.y_off)) * sc);
    pen_x_m = clamp_pen(longint'(pen_x_m) + ((longint'(g.advance) * sc) >>> FRAC));
    lim = longint'(limit_r);
    if (g.space && (longint'(pen_x_m) > lim || longint'(pen_x_m) + longint'(g.nww) > lim))
    begin
      pen_x_m = PEN_W'(start_x_r);
      pen_y_m = clamp_pen(longint'(pen_y_m) + ((longint'(lh_r) * sc) >>> FRAC));
      wraps++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // Result checker: each accepted quad against the oldest expectation.
  always @(posedge clk) begin
    quad_t want;
    logic [OUT_W-1:0] got_l;
    logic [OUT_W-1:0] got_t;
    logic [OUT_W-1:0] got_r;
    logic [OUT_W-1:0] got_b;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_l = m_axis_tdata[24:0];
      got_t = m_axis_tdata[49:25];
      got_r = m_axis_tdata[74:50];
      got_b = m_axis_tdata[99:75];
      if (quad_q.size() == 0) begin
        report_mismatch($sformatf("quad %h/%h/%h/%h with none expected",
                                  got_l, got_t, got_r, got_b));
      end else begin
        want = quad_q.pop_front();
        quads_checked++;
        if (got_l !== want.left)
          report_mismatch($sformatf("quad_left %h, expected %h", got_l, want.left));
        if (got_t !== want.top)
          report_mismatch($sformatf("quad_top %h, expected %h", got_t, want.top));
        if (got_r !== want.right)
          report_mismatch($sformatf("quad_right %h, expected %h", got_r, want.right));
        if (got_b !== want.bottom)
          report_mismatch($sformatf("quad_bottom %h, expected %h", got_b, want.bottom));
      end
    end
  end

  // Receiver backpressure.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Send one glyph request; entered and left at a falling edge.
  task automatic send_glyph(input glyph_t g, input bit typed, input quad_t fixed);
    quad_t pred;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, g.nww, g.advance, g.height, g.width, g.y_off, g.x_off};
    s_axis_tuser <= {g.space, g.first};
    do @(posedge clk); while (!s_axis_tready);
    layout_glyph(g, pred);
    quad_q.push_back(typed ? fixed : pred);
    glyphs_sent++;
    @(negedge clk);
  endtask

  // Hold off until every quad is back and the pipeline has emptied.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (quad_q.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    apply_cfg(idx, val);
    reg_writes++;
    @(negedge clk);
  endtask

  function automatic glyph_t mk_glyph(bit first, bit space, int x, int y, int w, int h,
                                      int adv, int nww);
    glyph_t g;
    g.first = first;
    g.space = space;
    g.x_off = 8'(x);
    g.y_off = 8'(y);
    g.width = 10'(w);
    g.height = 10'(h);
    g.advance = 8'(adv);
    g.nww = 16'(nww);
    return g;
  endfunction

  task automatic add_glyph(input glyph_t g);
    row_t r;
    r = '{kind: ROW_GLYPH, default: '0};
    r.g = g;
    plan.push_back(r);
  endtask

  task automatic add_checked(input glyph_t g, input int l, input int t, input int rt,
                             input int b);
    row_t r;
    r = '{kind: ROW_GLYPH, default: '0};
    r.g = g;
    r.typed = 1'b1;
    r.quad.left = OUT_W'(l);
    r.quad.top = OUT_W'(t);
    r.quad.right = OUT_W'(rt);
    r.quad.bottom = OUT_W'(b);
    plan.push_back(r);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
    row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.idx = idx;
    r.val = CFG_W'(val);
    plan.push_back(r);
  endtask

  // Random text: words of letters separated by spaces, some noise glyphs.
  task automatic next_text_glyph(output glyph_t g);
    g = mk_glyph(0, 0, 0, 0, 0, 0, 0, 0);
    if ($urandom_range(99) < 15) begin
      g.first = 1'($urandom);
      g.space = 1'($urandom);
      g.x_off = 8'($urandom);
      g.y_off = 8'($urandom);
      g.width = 10'($urandom);
      g.height = 10'($urandom);
      g.advance = 8'($urandom);
      g.nww = 16'($urandom);
    end else if (word_left == 0) begin
      word_left = $urandom_range(1, 9);
      g.space = 1'b1;
      g.advance = 8'($urandom_range(3, 16));
      g.nww = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
    end else begin
      word_left--;
      g.first = ($urandom_range(39) == 0);
      g.x_off = 8'($urandom_range(0, 12) - 4);
      g.y_off = 8'($urandom_range(0, 24) - 20);
      g.width = 10'($urandom_range(0, 40));
      g.height = 10'($urandom_range(0, 40));
      g.advance = 8'($urandom_range(4, 40));
    end
  endtask

  initial begin
    glyph_t g;
    quad_t none;
    int sx;
    none = '{default: '0};
    pen_x_m = '0;
    pen_y_m = '0;
    start_x_r = '0;
    start_y_r = '0;
    limit_r = 16'sd32767;
    scale_r = 16'd256;
    lh_r = 10'd16;

    // Directed table. From reset the pen sits at the origin with scale 1.0.
    add_checked(mk_glyph(0, 0, 1, 2, 3, 4, 5, 0), 256, 512, 1024, 1536);
    add_checked(mk_glyph(1, 0, 1, 2, 3, 4, 5, 0), 256, 512, 1024, 1536);
    add_checked(mk_glyph(0, 1, 0, 0, 0, 0, 4, 0), 1280, 0, 1280, 0);
    // Next word too wide: wraps to column 0, one line down.
    add_checked(mk_glyph(0, 1, 0, 0, 0, 0, 4, 65535), 2304, 0, 2304, 0);
    add_checked(mk_glyph(0, 0, -128, 127, 1023, 1023, 255, 0), -32768, 36608, 229120,
                298496);
    // Largest scale and extreme start: edges and pen saturate.
    add_cfg(CFG_TEXT_SCALE, 65535);
    add_cfg(CFG_PEN_START_X, -32768);
    add_cfg(CFG_PEN_START_Y, 32767);
    add_cfg(CFG_WRAP_LIMIT_X, 32767);
    add_cfg(CFG_LINE_HEIGHT, 1023);
    add_glyph(mk_glyph(1, 0, 127, 127, 1023, 1023, 255, 0));
    add_glyph(mk_glyph(0, 0, 127, -128, 1023, 0, 255, 0));
    add_glyph(mk_glyph(0, 0, -128, -128, 0, 1023, 255, 0));
    add_glyph(mk_glyph(0, 1, 0, 0, 0, 0, 255, 0));
    add_glyph(mk_glyph(0, 0, -128, -128, 0, 0, 0, 0));
    // Lowest limit: every space wraps; zero scale collapses the quads.
    add_cfg(CFG_WRAP_LIMIT_X, -32768);
    add_glyph(mk_glyph(1, 1, 5, 5, 10, 10, 8, 0));
    add_cfg(CFG_TEXT_SCALE, 0);
    add_cfg(CFG_LINE_HEIGHT, 0);
    add_glyph(mk_glyph(1, 1, 127, 127, 1023, 1023, 255, 65535));
    add_glyph(mk_glyph(0, 0, -128, 127, 1023, 1023, 255, 0));
    // Writes past the register list leave everything as it was.
    add_cfg(CFG_SPARE_LO, 65535);
    add_cfg(CFG_SPARE_MID, 65535);
    add_cfg(CFG_SPARE_HI, 65535);
    add_glyph(mk_glyph(0, 1, 3, 3, 3, 3, 3, 3));
    // Ordinary setting: pen past the limit versus next word crossing it.
    add_cfg(CFG_TEXT_SCALE, 256);
    add_cfg(CFG_LINE_HEIGHT, 16);
    add_cfg(CFG_PEN_START_X, 10);
    add_cfg(CFG_PEN_START_Y, -20);
    add_cfg(CFG_WRAP_LIMIT_X, 100);
    add_glyph(mk_glyph(1, 0, 1, -10, 8, 12, 60, 0));
    add_glyph(mk_glyph(0, 1, 0, 0, 0, 0, 10, 20));
    add_glyph(mk_glyph(0, 1, 0, 0, 0, 0, 10, 21));
    add_glyph(mk_glyph(0, 0, 1, -10, 8, 12, 95, 0));
    add_glyph(mk_glyph(0, 1, 0, 0, 0, 0, 0, 0));

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind != ROW_CFG) wait_idle();
        write_reg(plan[i].idx, plan[i].val);
        if (i == plan.size() - 1 || plan[i+1].kind != ROW_CFG) cfg_wr_en <= 1'b0;
      end else begin
        send_glyph(plan[i].g, plan[i].typed, plan[i].quad);
      end
    end

    // Random text under four idling patterns, new registers for each.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 65; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 65; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      wait_idle();
      sx = $urandom_range(0, 400) - 200;
      write_reg(CFG_PEN_START_X, CFG_W'(sx));
      write_reg(CFG_PEN_START_Y, CFG_W'($urandom_range(0, 400) - 200));
      write_reg(CFG_WRAP_LIMIT_X, (ph == 3) ? CFG_W'($urandom)
                                            : CFG_W'(sx + $urandom_range(150, 2500)));
      write_reg(CFG_TEXT_SCALE, (ph == 3) ? CFG_W'($urandom)
                                          : CFG_W'($urandom_range(128, 640)));
      write_reg(CFG_LINE_HEIGHT, (ph == 3) ? CFG_W'($urandom)
                                           : CFG_W'($urandom_range(8, 48)));
      cfg_wr_en <= 1'b0;
      word_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        next_text_glyph(g);
        if (n == 0) g.first = 1'b1;
        send_glyph(g, 1'b0, none);
      end
    end

    // Drain and let the pipeline settle.
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (quad_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Laid out %0d glyphs, checked %0d quads, %0d line wraps in the model.",
             glyphs_sent, quads_checked, wraps);
    $display("Made %0d register writes across directed and random settings.", reg_writes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
